// ===== hw/rtl/odcc_pkg.sv =====
// shared constants, types and the bayer table for the ordered dither color cube
`default_nettype none

package odcc_pkg;

    // field widths
    localparam int unsigned CompW    = 8;
    localparam int unsigned PhaseW   = 3;
    localparam int unsigned LevelW   = 8;
    localparam int unsigned BayerW   = 6;
    localparam int unsigned ThrW     = 7;
    localparam int unsigned ProdW    = 2 * CompW;
    localparam int unsigned IndexW   = 10;
    localparam int unsigned CfgIdxW  = 2;
    localparam int unsigned NumChan  = 3;

    // configuration register indexes
    typedef enum logic [CfgIdxW-1:0] {
        CFG_RED_LEVELS   = 2'd0,
        CFG_GREEN_LEVELS = 2'd1,
        CFG_BLUE_LEVELS  = 2'd2,
        CFG_UNUSED       = 2'd3
    } t_cfg_idx;

    // channel lane numbers
    localparam int unsigned ChRed   = 0;
    localparam int unsigned ChGreen = 1;
    localparam int unsigned ChBlue  = 2;

    // reset values of the level registers
    localparam logic [LevelW-1:0] RedLevelsRst   = 8'd6;
    localparam logic [LevelW-1:0] GreenLevelsRst = 8'd6;
    localparam logic [LevelW-1:0] BlueLevelsRst  = 8'd4;

    // 8x8 bayer matrix, [row][col]
    localparam logic [BayerW-1:0] BAYER [8][8] = '{
        '{6'd0,  6'd32, 6'd8,  6'd40, 6'd2,  6'd34, 6'd10, 6'd42},
        '{6'd48, 6'd16, 6'd56, 6'd24, 6'd50, 6'd18, 6'd58, 6'd26},
        '{6'd12, 6'd44, 6'd4,  6'd36, 6'd14, 6'd46, 6'd6,  6'd38},
        '{6'd60, 6'd28, 6'd52, 6'd20, 6'd62, 6'd30, 6'd54, 6'd22},
        '{6'd3,  6'd35, 6'd11, 6'd43, 6'd1,  6'd33, 6'd9,  6'd41},
        '{6'd51, 6'd19, 6'd59, 6'd27, 6'd49, 6'd17, 6'd57, 6'd25},
        '{6'd15, 6'd47, 6'd7,  6'd39, 6'd13, 6'd45, 6'd5,  6'd37},
        '{6'd63, 6'd31, 6'd55, 6'd23, 6'd61, 6'd29, 6'd53, 6'd21}
    };

    // bayer threshold at a pixel phase
    function automatic logic [BayerW-1:0] bayer_at(
        input logic [PhaseW-1:0] row,
        input logic [PhaseW-1:0] col
    );
        return BAYER[row][col];
    endfunction

    // levels minus one, held at zero below two levels
    function automatic logic [LevelW-1:0] level_span(input logic [LevelW-1:0] levels);
        return (levels != '0) ? (levels - 8'd1) : '0;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/ordered_dither_color_cube.sv =====
// ordered dither of an rgb pixel onto a color cube index, four stage pipeline
//
// channel   direction   transaction                          handshake
// in        input       red, green, blue, phases, seg end    i_in_valid / o_in_ready
// out       output      color_index, segment_end_out         o_out_valid / i_out_ready
// cfg       input       level register index and data        i_cfg_valid / o_cfg_ready
//
// one pixel per cycle sustained while the output is ready; a result is registered through
// every stage before it is valid at the output
// stages: channel products, threshold and level pick, level times weight, index sum
// synchronous active low reset empties the pipeline and loads 6, 6, 4 levels
// a stall at the output backs up stage by stage; each stage holds its data until taken
// the config port is always ready
`default_nettype none

module ordered_dither_color_cube (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    // pixel input
    input  wire                               i_in_valid,
    output logic                              o_in_ready,
    input  wire  [odcc_pkg::CompW-1:0]        i_red,
    input  wire  [odcc_pkg::CompW-1:0]        i_green,
    input  wire  [odcc_pkg::CompW-1:0]        i_blue,
    input  wire  [odcc_pkg::PhaseW-1:0]       i_col_phase,
    input  wire  [odcc_pkg::PhaseW-1:0]       i_row_phase,
    input  wire                               i_segment_end,
    // index output
    output logic                              o_out_valid,
    input  wire                               i_out_ready,
    output logic [odcc_pkg::IndexW-1:0]       o_color_index,
    output logic                              o_segment_end_out,
    // configuration writes
    input  wire                               i_cfg_valid,
    output logic                              o_cfg_ready,
    input  wire  [odcc_pkg::CfgIdxW-1:0]      i_cfg_index,
    input  wire  [odcc_pkg::LevelW-1:0]       i_cfg_data
);

    import odcc_pkg::*;

    // configuration registers
    logic [LevelW-1:0] r_levels [NumChan];
    logic [CompW-1:0]  r_red_mult;
    logic [CompW-1:0]  n_red_mult;
    logic [ProdW-1:0]  w_gb_prod;
    t_cfg_idx          w_cfg_idx;

    assign o_cfg_ready = 1'b1;
    assign w_cfg_idx   = t_cfg_idx'(i_cfg_index);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_levels[ChRed]   <= RedLevelsRst;
            r_levels[ChGreen] <= GreenLevelsRst;
            r_levels[ChBlue]  <= BlueLevelsRst;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (w_cfg_idx)
                CFG_RED_LEVELS:   r_levels[ChRed]   <= i_cfg_data;
                CFG_GREEN_LEVELS: r_levels[ChGreen] <= i_cfg_data;
                CFG_BLUE_LEVELS:  r_levels[ChBlue]  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // red weight is green times blue levels, low byte only matters
    assign w_gb_prod  = ProdW'(r_levels[ChGreen]) * ProdW'(r_levels[ChBlue]);
    assign n_red_mult = w_gb_prod[CompW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_red_mult <= CompW'(ProdW'(GreenLevelsRst) * ProdW'(BlueLevelsRst));
        end else begin
            r_red_mult <= n_red_mult;
        end
    end

    // stage handshake: a stage moves when the next one is empty or moving
    logic r_v1, r_v2, r_v3, r_v4;
    logic w_rdy1, w_rdy2, w_rdy3, w_rdy4;

    assign w_rdy4      = !r_v4 || i_out_ready;
    assign w_rdy3      = !r_v3 || w_rdy4;
    assign w_rdy2      = !r_v2 || w_rdy3;
    assign w_rdy1      = !r_v1 || w_rdy2;
    assign o_in_ready  = w_rdy1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (w_rdy1) r_v1 <= i_in_valid;
            if (w_rdy2) r_v2 <= r_v1;
            if (w_rdy3) r_v3 <= r_v2;
            if (w_rdy4) r_v4 <= r_v3;
        end
    end

    // stage 1: value times span per channel, bayer lookup
    logic [CompW-1:0]  w_pix [NumChan];
    logic [ProdW-1:0]  r_t1  [NumChan];
    logic [BayerW-1:0] r_bayer1;
    logic              r_seg1;

    assign w_pix[ChRed]   = i_red;
    assign w_pix[ChGreen] = i_green;
    assign w_pix[ChBlue]  = i_blue;

    always_ff @(posedge i_clk) begin
        if (w_rdy1) begin
            for (int c = 0; c < NumChan; c++) begin
                r_t1[c] <= ProdW'(w_pix[c]) * ProdW'(level_span(r_levels[c]));
            end
            r_bayer1 <= bayer_at(i_row_phase, i_col_phase);
            r_seg1   <= i_segment_end;
        end
    end

    // stage 2: threshold from the fraction, pick low or low plus one
    logic [ProdW-2:0]  w_thr_sum [NumChan];
    logic [ThrW-1:0]   w_thr     [NumChan];
    logic [LevelW-1:0] r_level2  [NumChan];
    logic              r_seg2;

    always_comb begin
        for (int c = 0; c < NumChan; c++) begin
            // fraction times 65 is fraction shifted by six plus fraction
            w_thr_sum[c] = {1'b0, r_t1[c][CompW-1:0], 6'b0}
                         + (ProdW-1)'(r_t1[c][CompW-1:0]);
            w_thr[c]     = w_thr_sum[c][ProdW-2 -: ThrW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy2) begin
            for (int c = 0; c < NumChan; c++) begin
                r_level2[c] <= r_t1[c][ProdW-1:CompW]
                             + LevelW'(ThrW'(r_bayer1) < w_thr[c]);
            end
            r_seg2 <= r_seg1;
        end
    end

    // stage 3: level times channel weight, kept to a byte
    logic [CompW-1:0] w_mult [NumChan];
    logic [ProdW-1:0] w_term [NumChan];
    logic [CompW-1:0] r_term3 [NumChan];
    logic             r_seg3;

    assign w_mult[ChRed]   = r_red_mult;
    assign w_mult[ChGreen] = r_levels[ChBlue];
    assign w_mult[ChBlue]  = CompW'(1);

    always_comb begin
        for (int c = 0; c < NumChan; c++) begin
            w_term[c] = ProdW'(r_level2[c]) * ProdW'(w_mult[c]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy3) begin
            for (int c = 0; c < NumChan; c++) begin
                r_term3[c] <= w_term[c][CompW-1:0];
            end
            r_seg3 <= r_seg2;
        end
    end

    // stage 4: sum of the three terms into the output register
    logic [IndexW-1:0] r_index4;
    logic              r_seg4;

    always_ff @(posedge i_clk) begin
        if (w_rdy4) begin
            r_index4 <= IndexW'(r_term3[ChRed]) + IndexW'(r_term3[ChGreen])
                      + IndexW'(r_term3[ChBlue]);
            r_seg4   <= r_seg3;
        end
    end

    assign o_out_valid       = r_v4;
    assign o_color_index     = r_index4;
    assign o_segment_end_out = r_seg4;

    // a draining output never blocks the input
    a_no_block_when_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_ready |-> o_in_ready)
        else $error("input stalled while output drains");

    // a stalled first stage keeps its item
    a_stage1_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v1 && !w_rdy2) |=> r_v1)
        else $error("stage 1 item lost under stall");

    // red weight follows the green and blue level registers
    a_red_mult_tracks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        1'b1 |=> (r_red_mult == CompW'(ProdW'($past(r_levels[ChGreen]))
                                     * ProdW'($past(r_levels[ChBlue])))))
        else $error("red weight out of step with level registers");

endmodule

`default_nettype wire

// ===== bench/tb.sv =====
// testbench for the ordered dither color cube: directed corners, then random pixel streams
`timescale 1ns / 100ps

module tb;
    import odcc_pkg::*;

    localparam int unsigned CYCLE_LIMIT  = 200000;
    localparam int unsigned PIPE_SETTLE  = 8;
    localparam int unsigned MAX_REPORTS  = 10;
    localparam int unsigned RAND_CHUNKS  = 11;
    localparam int unsigned CHUNK_PIXELS = 50;

    // own copy of the 8x8 threshold map, [row][col]
    localparam logic [5:0] DITHER_MAP [8][8] = '{
        '{6'd0,  6'd32, 6'd8,  6'd40, 6'd2,  6'd34, 6'd10, 6'd42},
        '{6'd48, 6'd16, 6'd56, 6'd24, 6'd50, 6'd18, 6'd58, 6'd26},
        '{6'd12, 6'd44, 6'd4,  6'd36, 6'd14, 6'd46, 6'd6,  6'd38},
        '{6'd60, 6'd28, 6'd52, 6'd20, 6'd62, 6'd30, 6'd54, 6'd22},
        '{6'd3,  6'd35, 6'd11, 6'd43, 6'd1,  6'd33, 6'd9,  6'd41},
        '{6'd51, 6'd19, 6'd59, 6'd27, 6'd49, 6'd17, 6'd57, 6'd25},
        '{6'd15, 6'd47, 6'd7,  6'd39, 6'd13, 6'd45, 6'd5,  6'd37},
        '{6'd63, 6'd31, 6'd55, 6'd23, 6'd61, 6'd29, 6'd53, 6'd21}
    };

    typedef struct packed {
        logic [IndexW-1:0] index;
        logic              seg_end;
    } t_cube_result;

    // clock, reset and block inputs, all known from time zero
    logic                i_clk         = 1'b0;
    logic                i_rst_n       = 1'b0;
    logic                i_in_valid    = 1'b0;
    logic [CompW-1:0]    i_red         = '0;
    logic [CompW-1:0]    i_green       = '0;
    logic [CompW-1:0]    i_blue        = '0;
    logic [PhaseW-1:0]   i_col_phase   = '0;
    logic [PhaseW-1:0]   i_row_phase   = '0;
    logic                i_segment_end = 1'b0;
    logic                i_out_ready   = 1'b0;
    logic                i_cfg_valid   = 1'b0;
    logic [CfgIdxW-1:0]  i_cfg_index   = '0;
    logic [LevelW-1:0]   i_cfg_data    = '0;

    logic                o_in_ready;
    logic                o_out_valid;
    logic [IndexW-1:0]   o_color_index;
    logic                o_segment_end_out;
    logic                o_cfg_ready;

    // predictor copy of the level registers
    logic [LevelW-1:0]   cube_red_levels   = RedLevelsRst;
    logic [LevelW-1:0]   cube_green_levels = GreenLevelsRst;
    logic [LevelW-1:0]   cube_blue_levels  = BlueLevelsRst;

    t_cube_result        pending_indexes [$];
    t_cube_result        oldest_index;
    int unsigned         send_idle_pct  = 10;
    int unsigned         recv_idle_pct  = 59;
    int unsigned         mismatch_count = 0;
    int unsigned         checked_count  = 0;
    int unsigned         pixel_count    = 0;
    int unsigned         cube_settings  = 0;
    int unsigned         cycle_count    = 0;

    ordered_dither_color_cube u_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_red             (i_red),
        .i_green           (i_green),
        .i_blue            (i_blue),
        .i_col_phase       (i_col_phase),
        .i_row_phase       (i_row_phase),
        .i_segment_end     (i_segment_end),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_color_index     (o_color_index),
        .o_segment_end_out (o_segment_end_out),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data)
    );

    // 10 ns clock
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // run guard
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results still pending",
                     cycle_count, pending_indexes.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // dither one component and weight its chosen shade, kept to 8 bits
    function automatic logic [7:0] shade_term(
        input logic [CompW-1:0]  value,
        input logic [LevelW-1:0] levels,
        input logic [15:0]       weight,
        input logic [5:0]        map_entry
    );
        logic [LevelW-1:0] span;
        logic [15:0]       scaled;
        logic [7:0]        base_shade;
        logic [14:0]       frac_x65;
        logic [7:0]        cutoff;
        logic [7:0]        shade;
        logic [23:0]       weighted;
        span       = (levels != '0) ? levels - 8'd1 : '0;
        scaled     = value * span;
        base_shade = scaled[15:8];
        frac_x65   = scaled[7:0] * 15'd65;
        cutoff     = {1'b0, frac_x65[14:8]};
        shade      = ({2'b00, map_entry} < cutoff) ? base_shade + 8'd1 : base_shade;
        weighted   = shade * weight;
        return weighted[7:0];
    endfunction

    // expected cube index for one pixel under the current levels
    function automatic t_cube_result dither_index(
        input logic [CompW-1:0]  r,
        input logic [CompW-1:0]  g,
        input logic [CompW-1:0]  b,
        input logic [PhaseW-1:0] col,
        input logic [PhaseW-1:0] row,
        input logic              seg
    );
        t_cube_result res;
        logic [5:0]   map_entry;
        logic [15:0]  red_weight;
        map_entry   = DITHER_MAP[row][col];
        red_weight  = cube_green_levels * cube_blue_levels;
        res.index   = {2'b00, shade_term(r, cube_red_levels, red_weight, map_entry)}
                    + {2'b00, shade_term(g, cube_green_levels, {8'h00, cube_blue_levels},
                                         map_entry)}
                    + {2'b00, shade_term(b, cube_blue_levels, 16'd1, map_entry)};
        res.seg_end = seg;
        return res;
    endfunction

    task automatic note_failure(input string what, input int unsigned exp_val,
                                input int unsigned act_val);
        if (mismatch_count < MAX_REPORTS)
            $display("mismatch at cycle %0d: %s expected %0d got %0d",
                     cycle_count, what, exp_val, act_val);
        mismatch_count++;
    endtask

    // output side stalls at random
    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // compare each taken result against the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_indexes.size() == 0) begin
                note_failure("unexpected result, index", 0, o_color_index);
            end else begin
                oldest_index = pending_indexes.pop_front();
                if (oldest_index.index !== o_color_index)
                    note_failure("color_index", oldest_index.index, o_color_index);
                if (oldest_index.seg_end !== o_segment_end_out)
                    note_failure("segment_end_out", oldest_index.seg_end, o_segment_end_out);
                checked_count++;
            end
        end
    end

    // one pixel transaction; valid stays high into the next call unless a gap is taken
    task automatic send_pixel(
        input logic [CompW-1:0]  r,
        input logic [CompW-1:0]  g,
        input logic [CompW-1:0]  b,
        input logic [PhaseW-1:0] col,
        input logic [PhaseW-1:0] row,
        input logic              seg
    );
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_red         <= r;
        i_green       <= g;
        i_blue        <= b;
        i_col_phase   <= col;
        i_row_phase   <= row;
        i_segment_end <= seg;
        do @(posedge i_clk); while (!o_in_ready);
        pending_indexes.push_back(dither_index(r, g, b, col, row, seg));
        pixel_count++;
    endtask

    // sender holds off until every result is back and the pipeline is empty
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (pending_indexes.size() != 0) @(posedge i_clk);
        repeat (PIPE_SETTLE) @(posedge i_clk);
    endtask

    // one register transaction; the caller lowers valid after its last write
    task automatic write_level(input t_cfg_idx idx, input logic [LevelW-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_RED_LEVELS:   cube_red_levels   = value;
            CFG_GREEN_LEVELS: cube_green_levels = value;
            CFG_BLUE_LEVELS:  cube_blue_levels  = value;
            default: ;
        endcase
    endtask

    task automatic set_cube(input logic [LevelW-1:0] r_lv, input logic [LevelW-1:0] g_lv,
                            input logic [LevelW-1:0] b_lv);
        wait_idle();
        write_level(CFG_RED_LEVELS, r_lv);
        write_level(CFG_GREEN_LEVELS, g_lv);
        write_level(CFG_BLUE_LEVELS, b_lv);
        i_cfg_valid <= 1'b0;
        cube_settings++;
    endtask

    function automatic logic [CompW-1:0] rand_component();
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic send_random_pixel();
        send_pixel(rand_component(), rand_component(), rand_component(),
                   3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)),
                   ($urandom_range(0, 7) == 0));
    endtask

    // reset levels 6, 6, 4 with black and white pixels at corner phases and mixed pixels at other phases
    task automatic test_reset_levels();
        send_pixel(8'd0,   8'd0,   8'd0,   3'd0, 3'd0, 1'b0);
        send_pixel(8'd255, 8'd255, 8'd255, 3'd7, 3'd7, 1'b1);
        send_pixel(8'd128, 8'd64,  8'd200, 3'd3, 3'd5, 1'b0);
        send_pixel(8'd1,   8'd254, 8'd127, 3'd6, 3'd2, 1'b1);
    endtask

    // a write to the spare index must leave every level untouched
    task automatic test_unused_register();
        wait_idle();
        write_level(CFG_UNUSED, 8'hFF);
        i_cfg_valid <= 1'b0;
        send_pixel(8'd200, 8'd100, 8'd50,  3'd1, 3'd4, 1'b0);
        send_pixel(8'd255, 8'd255, 8'd255, 3'd0, 3'd0, 1'b1);
    endtask

    // smallest and largest level settings, term wrap, and levels below two
    task automatic test_level_extremes();
        set_cube(8'd2, 8'd2, 8'd2);
        send_pixel(8'd127, 8'd128, 8'd255, 3'd2, 3'd1, 1'b0);
        send_pixel(8'd0,   8'd255, 8'd128, 3'd5, 3'd6, 1'b1);
        set_cube(8'd128, 8'd128, 8'd128);
        send_pixel(8'd255, 8'd255, 8'd255, 3'd4, 3'd3, 1'b0);
        send_pixel(8'd77,  8'd190, 8'd33,  3'd1, 3'd7, 1'b0);
        set_cube(8'd255, 8'd255, 8'd255);
        send_pixel(8'd255, 8'd1,   8'd170, 3'd7, 3'd0, 1'b1);
        send_pixel(8'd99,  8'd254, 8'd255, 3'd0, 3'd7, 1'b0);
        set_cube(8'd0, 8'd1, 8'd0);
        send_pixel(8'd255, 8'd255, 8'd255, 3'd0, 3'd0, 1'b0);
        send_pixel(8'd128, 8'd200, 8'd10,  3'd6, 3'd5, 1'b1);
    endtask

    // fraction near one gives cutoff 64, above even the largest map entry
    task automatic test_full_fraction();
        set_cube(8'd2, 8'd2, 8'd2);
        send_pixel(8'd255, 8'd254, 8'd253, 3'd0, 3'd7, 1'b0);
        set_cube(8'd3, 8'd3, 8'd3);
        send_pixel(8'd255, 8'd255, 8'd255, 3'd0, 3'd7, 1'b1);
    endtask

    // end of segment flag passes through on its own pixel
    task automatic test_segment_flag();
        set_cube(RedLevelsRst, GreenLevelsRst, BlueLevelsRst);
        send_pixel(8'd90, 8'd90, 8'd90, 3'd2, 3'd2, 1'b1);
        send_pixel(8'd90, 8'd90, 8'd90, 3'd3, 3'd2, 1'b0);
    endtask

    // random cube settings, each followed by a stream of random pixels
    task automatic test_random_stream();
        for (int chunk = 0; chunk < RAND_CHUNKS; chunk++) begin
            if (chunk < 4) begin
                send_idle_pct = 10;
                recv_idle_pct = 59;
            end else if (chunk < 8) begin
                send_idle_pct = 59;
                recv_idle_pct = 10;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            if ($urandom_range(0, 4) == 0)
                set_cube(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                         8'($urandom_range(0, 255)));
            else
                set_cube(8'($urandom_range(2, 8)), 8'($urandom_range(2, 8)),
                         8'($urandom_range(2, 4)));
            for (int i = 0; i < CHUNK_PIXELS; i++) begin
                // let the pipeline run dry mid stream once
                if (chunk == 6 && i == CHUNK_PIXELS / 2)
                    wait_idle();
                send_random_pixel();
            end
        end
    endtask

    // main sequence
    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_levels();
        test_unused_register();
        test_level_extremes();
        test_full_fraction();
        test_segment_flag();
        test_random_stream();

        i_in_valid <= 1'b0;
        while (pending_indexes.size() != 0) @(posedge i_clk);
        repeat (PIPE_SETTLE) @(posedge i_clk);

        if (pending_indexes.size() != 0)
            note_failure("results never delivered", 0, pending_indexes.size());
        $display("sent %0d pixels under %0d cube settings, %0d indexes checked",
                 pixel_count, cube_settings, checked_count);
        $display("%0d mismatches over %0d cycles", mismatch_count, cycle_count);
        if (mismatch_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== ordered_dither_color_cube.f =====
hw/rtl/odcc_pkg.sv
hw/rtl/ordered_dither_color_cube.sv
bench/tb.sv
